[hdl/crc8fr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package crc8fr_pkg;

	localparam int HDR_LEN          = 12;
	localparam int HDR_CNT_W        = 4;
	localparam int CRC_START        = 3;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam int MAX_DATA_LEN_DEF = 4096;
	localparam int FRAME_LEN_W      = 13;
	localparam int SEQ_W            = 32;
	localparam int TDATA_W          = 56;
	localparam int TUSER_W          = 3;
	localparam int PADDR_W          = 3;
	localparam logic [15:0] MARKER_RST = 16'h0000;

	typedef enum logic [1:0] {
		ST_BUSY = 2'd0,
		ST_GOOD = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]             data_byte;
		logic                   byte_valid;
		logic                   last;
		status_t                status;
		logic [SEQ_W-1:0]       seq_number;
		logic [FRAME_LEN_W-1:0] frame_length;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/crc8_frame_receiver_top.sv]
// CRC-8 framed packet receiver.
// s_axis: one received byte per item (s_tdata). Each frame starts with a
// 12-byte little-endian header: marker, header CRC, data CRC, sequence
// number, length. A header is taken when the marker matches frame_marker,
// the CRC-8 (poly 0x07, init 0) over bytes 3..11 matches and the length is
// at most MAX_DATA_LEN; otherwise all twelve bytes are dropped.
// m_axis: one item per payload byte; tlast marks the last byte, whose tuser
// status carries the data CRC verdict (1 good, 2 mismatch). A zero-length
// frame yields a single item with byte_valid low on its twelfth header byte.
// APB: register 0 (byte address 0) holds frame_marker.
// Path: an accepted s_axis byte enters the input register, then the result
// register drives m_tvalid. Throughput: one byte per cycle while m_tready
// does not stall, set by the combinational CRC/counter update in between.
// Reset: clears the header counter, CRC, payload state and marker; stored
// items are discarded. A stalled m_tready holds the result register; the
// input register still takes one more item, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module crc8_frame_receiver_top
	import crc8fr_pkg::*;
#(
	parameter int MAX_DATA_LEN = MAX_DATA_LEN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,  // [7:0] rx_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,  // [7:0] data_byte, [39:8] seq_number,
	                                          // [52:40] frame_length, rest zero
	output logic [TUSER_W-1:0]      m_tuser,  // [0] byte_valid, [2:1] status
	output logic                    m_tlast,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        go;
	logic        out_free;
	logic        res_valid;
	res_t        res;
	logic [15:0] frame_marker;

	assign go       = valid_s1 && out_free;
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	crc8fr_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_marker (frame_marker)
	);

	crc8fr_deframer #(
		.MAX_DATA_LEN (MAX_DATA_LEN)
	) u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.byte_s1      (byte_s1),
		.frame_marker (frame_marker),
		.res_valid    (res_valid),
		.res          (res)
	);

	crc8fr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

[hdl/crc8fr_apb_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_apb_regs
	import crc8fr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output logic      [15:0]        frame_marker
);

	logic        sel_marker;
	logic [15:0] marker_q;

	assign pready       = 1'b1;
	assign sel_marker   = (paddr[PADDR_W-1] == 1'b0);
	assign frame_marker = marker_q;
	assign prdata       = sel_marker ? {16'h0000, marker_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
		end else if (psel && penable && pwrite && pready && sel_marker) begin
			marker_q <= pwdata[15:0];
		end
	end

endmodule
`default_nettype wire

[hdl/crc8fr_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_deframer
	import crc8fr_pkg::*;
#(
	parameter int MAX_DATA_LEN = MAX_DATA_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [7:0]  byte_s1,
	input  wire logic [15:0] frame_marker,
	output logic             res_valid,
	output res_t             res
);

	localparam int CNT_W = $clog2(MAX_DATA_LEN + 1);

	logic                 in_payload_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [7:0]           hdr_q [HDR_LEN];
	logic [7:0]           crc_q;
	logic [CNT_W-1:0]     pay_cnt_q;

	logic [7:0]       crc_upd;
	logic             hdr_last;
	logic [31:0]      len_w;
	logic             hdr_ok;
	logic             len_zero;
	logic [15:0]      len_lo;
	logic [CNT_W-1:0] pay_len;
	logic [CNT_W-1:0] pay_cnt_nx;
	logic             pay_end;

	always_comb begin
		crc_upd    = crc8_step(crc_q, byte_s1);
		hdr_last   = (hdr_cnt_q == HDR_CNT_W'(HDR_LEN - 1));
		len_w      = {byte_s1, hdr_q[10], hdr_q[9], hdr_q[8]};
		len_zero   = (len_w == 32'd0);
		hdr_ok     = ({hdr_q[1], hdr_q[0]} == frame_marker) && (crc_upd == hdr_q[2]) &&
			(len_w <= 32'(MAX_DATA_LEN));
		len_lo     = {hdr_q[9], hdr_q[8]};
		pay_len    = len_lo[CNT_W-1:0];
		pay_cnt_nx = pay_cnt_q + CNT_W'(1);
		pay_end    = (pay_cnt_nx >= pay_len);

		res.seq_number   = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
		res.frame_length = len_lo[FRAME_LEN_W-1:0];
		if (in_payload_q) begin
			res_valid      = go;
			res.data_byte  = byte_s1;
			res.byte_valid = 1'b1;
			res.last       = pay_end;
			if (!pay_end) begin
				res.status = ST_BUSY;
			end else if (crc_upd == hdr_q[3]) begin
				res.status = ST_GOOD;
			end else begin
				res.status = ST_BAD;
			end
		end else begin
			// empty frame: verdict comes with the header
			res_valid      = go && hdr_last && hdr_ok && len_zero;
			res.data_byte  = 8'h00;
			res.byte_valid = 1'b0;
			res.last       = 1'b1;
			res.status     = (hdr_q[3] == 8'h00) ? ST_GOOD : ST_BAD;
		end
	end

	for (genvar i = 0; i < HDR_LEN; i++) begin : g_hdr
		always_ff @(posedge clk) begin
			if (go && !in_payload_q && (hdr_cnt_q == HDR_CNT_W'(i))) begin
				hdr_q[i] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			crc_q        <= 8'h00;
			pay_cnt_q    <= '0;
		end else if (go) begin
			if (!in_payload_q) begin
				if (hdr_last) begin
					hdr_cnt_q    <= '0;
					crc_q        <= 8'h00;
					pay_cnt_q    <= '0;
					in_payload_q <= hdr_ok && !len_zero;
				end else begin
					hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
					if (hdr_cnt_q >= HDR_CNT_W'(CRC_START)) begin
						crc_q <= crc_upd;
					end
				end
			end else if (pay_end) begin
				in_payload_q <= 1'b0;
				crc_q        <= 8'h00;
				pay_cnt_q    <= '0;
			end else begin
				crc_q     <= crc_upd;
				pay_cnt_q <= pay_cnt_nx;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/crc8fr_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_out_reg
	import crc8fr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire res_t               res,
	output logic                    out_free,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,
	output logic [TUSER_W-1:0]      m_tuser,
	output logic                    m_tlast
);

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tlast  = res_q.last;
	assign m_tuser  = {res_q.status, res_q.byte_valid};
	assign m_tdata  = {TDATA_W'({res_q.frame_length, res_q.seq_number, res_q.data_byte})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

[hdl/crc8fr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module crc8fr_checker
	import crc8fr_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic [TUSER_W-1:0] m_tuser,
	input wire logic               m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_verdict_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[2:1] != ST_BUSY)))
		else $error("verdict not on last item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2:1] == ST_BUSY || m_tuser[2:1] == ST_GOOD ||
			m_tuser[2:1] == ST_BAD))
		else $error("bad status code");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'h00))
		else $error("empty-frame item malformed");

endmodule

bind crc8_frame_receiver_top crc8fr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
